### design/spm_pkg.sv
// shared types and constants for the sparse polynomial multiplier
// no dependencies

package spm_pkg;

   localparam int IdxWidth  = 3;
   localparam int CntWidth  = 4;
   localparam int CoefWidth = 16;
   localparam int ExpWidth  = 15;
   localparam int ProdWidth = 32;
   localparam int PexpWidth = 16;
   localparam int SumWidth  = 38;

   typedef struct packed {
      logic                load;
      logic                scan_clr;
      logic                pair_vld;
      logic [IdxWidth-1:0] idx_i;
      logic [IdxWidth-1:0] idx_j;
      logic                commit;
      logic                emit_pend;
      logic                emit_final;
      logic                job_clr;
   } cmd_type;

   typedef struct packed {
      logic                close;
      logic [CntWidth-1:0] first_count;
      logic [CntWidth-1:0] second_count;
      logic                best_found;
      logic                best_nonzero;
      logic                pend_valid;
      logic                rsp_free;
   } status_type;

endpackage

### design/spm_if.sv
// request and response channel interfaces for the sparse polynomial multiplier
// depends on spm_pkg

interface spm_req_if;
   logic                                 valid;
   logic                                 ready;
   logic                                 poly_select;
   logic signed [spm_pkg::CoefWidth-1:0] term_coefficient;
   logic        [spm_pkg::ExpWidth-1:0]  term_exponent;
   logic                                 last_term;

   modport source (output valid, poly_select, term_coefficient, term_exponent, last_term,
                   input ready);
   modport sink   (input valid, poly_select, term_coefficient, term_exponent, last_term,
                   output ready);
endinterface

interface spm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [spm_pkg::SumWidth-1:0]  product_coefficient;
   logic        [spm_pkg::PexpWidth-1:0] product_exponent;
   logic                                term_valid;
   logic                                capacity_overflow;
   logic                                last_result;

   modport source (output valid, product_coefficient, product_exponent, term_valid,
                   capacity_overflow, last_result, input ready);
   modport sink   (input valid, product_coefficient, product_exponent, term_valid,
                   capacity_overflow, last_result, output ready);
endinterface

### design/spm_ctrl.sv
// controller: load phase, pair scans per output exponent, result emission
// depends on spm_pkg

module spm_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  spm_pkg::status_type status,
   output spm_pkg::cmd_type    cmd
);

   localparam logic [2:0] StLoad   = 3'd0;
   localparam logic [2:0] StScan   = 3'd1;
   localparam logic [2:0] StDrain0 = 3'd2;
   localparam logic [2:0] StDrain1 = 3'd3;
   localparam logic [2:0] StDecide = 3'd4;
   localparam logic [2:0] StPush   = 3'd5;
   localparam logic [2:0] StFinal  = 3'd6;

   logic [2:0]                   state_ff, state_in;
   logic [spm_pkg::IdxWidth-1:0] i_ff, i_in, j_ff, j_in;
   logic [spm_pkg::CntWidth-1:0] fc_m1, sc_m1;

   assign fc_m1     = status.first_count - spm_pkg::CntWidth'(1);
   assign sc_m1     = status.second_count - spm_pkg::CntWidth'(1);
   assign req_ready = (state_ff == StLoad);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      cmd      = '0;
      cmd.idx_i = i_ff;
      cmd.idx_j = j_ff;
      case (state_ff)
         StLoad: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               if (status.close) begin
                  cmd.scan_clr = 1'b1;
                  i_in = '0;
                  j_in = '0;
                  state_in = StScan;
               end
            end
         end
         StScan: begin
            if (status.first_count == '0 || status.second_count == '0) begin
               state_in = StDrain0;
            end else begin
               cmd.pair_vld = 1'b1;
               if (j_ff == sc_m1[spm_pkg::IdxWidth-1:0]) begin
                  j_in = '0;
                  if (i_ff == fc_m1[spm_pkg::IdxWidth-1:0]) begin
                     state_in = StDrain0;
                  end else begin
                     i_in = i_ff + spm_pkg::IdxWidth'(1);
                  end
               end else begin
                  j_in = j_ff + spm_pkg::IdxWidth'(1);
               end
            end
         end
         StDrain0: state_in = StDrain1;
         StDrain1: state_in = StDecide;
         StDecide: begin
            if (!status.best_found) begin
               state_in = StFinal;
            end else if (status.best_nonzero && status.pend_valid) begin
               state_in = StPush;
            end else begin
               cmd.commit   = 1'b1;
               cmd.scan_clr = 1'b1;
               i_in = '0;
               j_in = '0;
               state_in = StScan;
            end
         end
         StPush: begin
            if (status.rsp_free) begin
               cmd.emit_pend = 1'b1;
               cmd.commit    = 1'b1;
               cmd.scan_clr  = 1'b1;
               i_in = '0;
               j_in = '0;
               state_in = StScan;
            end
         end
         StFinal: begin
            if (status.rsp_free) begin
               cmd.emit_final = 1'b1;
               cmd.job_clr    = 1'b1;
               state_in = StLoad;
            end
         end
         default: state_in = StLoad;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StLoad;
         i_ff     <= '0;
         j_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
      end
   end

endmodule

### design/spm_dp.sv
// datapath: term storage, multiply stage, max-exponent accumulator, result register
// depends on spm_pkg

module spm_dp #(
   parameter int MAX_TERMS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  spm_pkg::cmd_type                     cmd,
   output spm_pkg::status_type                  status,
   input  logic                                 req_poly_select,
   input  logic signed [spm_pkg::CoefWidth-1:0] req_term_coefficient,
   input  logic        [spm_pkg::ExpWidth-1:0]  req_term_exponent,
   input  logic                                 req_last_term,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [spm_pkg::SumWidth-1:0]  rsp_product_coefficient,
   output logic        [spm_pkg::PexpWidth-1:0] rsp_product_exponent,
   output logic                                 rsp_term_valid,
   output logic                                 rsp_capacity_overflow,
   output logic                                 rsp_last_result
);

   localparam int CW = spm_pkg::CntWidth;

   logic signed [spm_pkg::CoefWidth-1:0] first_coefs_ff  [MAX_TERMS];
   logic        [spm_pkg::ExpWidth-1:0]  first_exps_ff   [MAX_TERMS];
   logic signed [spm_pkg::CoefWidth-1:0] second_coefs_ff [MAX_TERMS];
   logic        [spm_pkg::ExpWidth-1:0]  second_exps_ff  [MAX_TERMS];
   logic [CW-1:0] first_count_ff, second_count_ff;
   logic          overflow_ff;

   logic                                 p_vld_ff;
   logic signed [spm_pkg::ProdWidth-1:0] p_prod_ff;
   logic        [spm_pkg::PexpWidth-1:0] p_exp_ff;

   logic                                 found_ff;
   logic signed [spm_pkg::SumWidth-1:0]  best_sum_ff;
   logic        [spm_pkg::PexpWidth-1:0] best_exp_ff;
   logic                                 bound_vld_ff;
   logic        [spm_pkg::PexpWidth-1:0] bound_ff;

   logic                                 pend_vld_ff;
   logic signed [spm_pkg::SumWidth-1:0]  pend_sum_ff;
   logic        [spm_pkg::PexpWidth-1:0] pend_exp_ff;

   logic                                 rsp_vld_ff;
   logic signed [spm_pkg::SumWidth-1:0]  rsp_coef_ff;
   logic        [spm_pkg::PexpWidth-1:0] rsp_exp_ff;
   logic                                 rsp_tv_ff, rsp_ovf_ff, rsp_last_ff;

   logic                                 in_range;
   logic signed [spm_pkg::SumWidth-1:0]  p_ext;

   assign in_range = !bound_vld_ff || (p_exp_ff < bound_ff);
   assign p_ext    = spm_pkg::SumWidth'(p_prod_ff);

   assign status.close        = req_poly_select && req_last_term;
   assign status.first_count  = first_count_ff;
   assign status.second_count = second_count_ff;
   assign status.best_found   = found_ff;
   assign status.best_nonzero = (best_sum_ff != '0);
   assign status.pend_valid   = pend_vld_ff;
   assign status.rsp_free     = !rsp_vld_ff || rsp_ready;

   // term storage
   always_ff @(posedge clock) begin
      if (cmd.load && !req_poly_select && first_count_ff < CW'(MAX_TERMS)) begin
         first_coefs_ff[first_count_ff[spm_pkg::IdxWidth-1:0]] <= req_term_coefficient;
         first_exps_ff[first_count_ff[spm_pkg::IdxWidth-1:0]]  <= req_term_exponent;
      end
      if (cmd.load && req_poly_select && second_count_ff < CW'(MAX_TERMS)) begin
         second_coefs_ff[second_count_ff[spm_pkg::IdxWidth-1:0]] <= req_term_coefficient;
         second_exps_ff[second_count_ff[spm_pkg::IdxWidth-1:0]]  <= req_term_exponent;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.job_clr) begin
         first_count_ff  <= '0;
         second_count_ff <= '0;
         overflow_ff     <= 1'b0;
      end else if (cmd.load) begin
         if (!req_poly_select) begin
            if (first_count_ff < CW'(MAX_TERMS)) begin
               first_count_ff <= first_count_ff + CW'(1);
            end else begin
               overflow_ff <= 1'b1;
            end
         end else begin
            if (second_count_ff < CW'(MAX_TERMS)) begin
               second_count_ff <= second_count_ff + CW'(1);
            end else begin
               overflow_ff <= 1'b1;
            end
         end
      end
   end

   // multiply stage
   always_ff @(posedge clock) begin
      p_prod_ff <= first_coefs_ff[cmd.idx_i] * second_coefs_ff[cmd.idx_j];
      p_exp_ff  <= spm_pkg::PexpWidth'(first_exps_ff[cmd.idx_i])
                 + spm_pkg::PexpWidth'(second_exps_ff[cmd.idx_j]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= cmd.pair_vld;
      end
   end

   // largest exponent below the bound, with its summed coefficient
   always_ff @(posedge clock) begin
      if (reset || cmd.scan_clr) begin
         found_ff <= 1'b0;
      end else if (p_vld_ff && in_range) begin
         if (!found_ff || p_exp_ff > best_exp_ff) begin
            found_ff    <= 1'b1;
            best_exp_ff <= p_exp_ff;
            best_sum_ff <= p_ext;
         end else if (p_exp_ff == best_exp_ff) begin
            best_sum_ff <= best_sum_ff + p_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.job_clr) begin
         bound_vld_ff <= 1'b0;
         pend_vld_ff  <= 1'b0;
      end else if (cmd.commit) begin
         bound_vld_ff <= 1'b1;
         bound_ff     <= best_exp_ff;
         if (best_sum_ff != '0) begin
            pend_vld_ff <= 1'b1;
            pend_sum_ff <= best_sum_ff;
            pend_exp_ff <= best_exp_ff;
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (cmd.emit_pend || cmd.emit_final) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_pend || cmd.emit_final) begin
         rsp_ovf_ff  <= overflow_ff;
         rsp_last_ff <= cmd.emit_final;
         if (pend_vld_ff) begin
            rsp_coef_ff <= pend_sum_ff;
            rsp_exp_ff  <= pend_exp_ff;
            rsp_tv_ff   <= 1'b1;
         end else begin
            rsp_coef_ff <= '0;
            rsp_exp_ff  <= '0;
            rsp_tv_ff   <= 1'b0;
         end
      end
   end

   assign rsp_valid               = rsp_vld_ff;
   assign rsp_product_coefficient = rsp_coef_ff;
   assign rsp_product_exponent    = rsp_exp_ff;
   assign rsp_term_valid          = rsp_tv_ff;
   assign rsp_capacity_overflow   = rsp_ovf_ff;
   assign rsp_last_result         = rsp_last_ff;

endmodule

### design/sparse_polynomial_multiply.sv
// Sparse polynomial multiplier. Terms of both polynomials load at one per cycle
// (up to MAX_TERMS each, extra terms dropped and flagged). The transaction that
// closes the second list starts the compute phase, during which the block takes
// no request. Each result term costs one scan of all n1*n2 term pairs through a
// single 16x16 multiplier, so a job of k distinct product exponents takes k + 1
// scans. Results leave through a registered output stage in descending
// exponent order.
// depends on spm_pkg, spm_if, spm_ctrl, spm_dp

module sparse_polynomial_multiply #(
   parameter int MAX_TERMS = 8
) (
   input logic       clock,
   input logic       reset,
   spm_req_if.sink   req_channel,
   spm_rsp_if.source rsp_channel
);

   spm_pkg::cmd_type    cmd;
   spm_pkg::status_type status;

   spm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_channel.valid),
      .req_ready (req_channel.ready),
      .status    (status),
      .cmd       (cmd)
   );

   spm_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
      .clock                   (clock),
      .reset                   (reset),
      .cmd                     (cmd),
      .status                  (status),
      .req_poly_select         (req_channel.poly_select),
      .req_term_coefficient    (req_channel.term_coefficient),
      .req_term_exponent       (req_channel.term_exponent),
      .req_last_term           (req_channel.last_term),
      .rsp_valid               (rsp_channel.valid),
      .rsp_ready               (rsp_channel.ready),
      .rsp_product_coefficient (rsp_channel.product_coefficient),
      .rsp_product_exponent    (rsp_channel.product_exponent),
      .rsp_term_valid          (rsp_channel.term_valid),
      .rsp_capacity_overflow   (rsp_channel.capacity_overflow),
      .rsp_last_result         (rsp_channel.last_result)
   );

endmodule

### design/spm_checker.sv
// port-level checks for the sparse polynomial multiplier, bound to the top level
// depends on sparse_polynomial_multiply

module spm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [37:0] rsp_product_coefficient,
   input logic [15:0] rsp_product_exponent,
   input logic        rsp_term_valid,
   input logic        rsp_last_result
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_term_valid |-> rsp_last_result)
      else $error("empty result not marked last");

   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_term_valid |->
         rsp_product_coefficient == '0 && rsp_product_exponent == '0)
      else $error("empty result carries a term");

   a_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_term_valid |-> rsp_product_coefficient != '0)
      else $error("zero coefficient emitted as a term");

endmodule

bind sparse_polynomial_multiply spm_checker u_spm_checker (
   .clock                   (clock),
   .reset                   (reset),
   .rsp_valid               (rsp_channel.valid),
   .rsp_ready               (rsp_channel.ready),
   .rsp_product_coefficient (rsp_channel.product_coefficient),
   .rsp_product_exponent    (rsp_channel.product_exponent),
   .rsp_term_valid          (rsp_channel.term_valid),
   .rsp_last_result         (rsp_channel.last_result)
);

### bench/tb_sparse_polynomial_multiply.sv
// self-checking bench for the sparse polynomial multiplier: directed table, then random jobs
// predicts each job's product terms and compares every response transaction in order
// depends on spm_pkg, spm_if and sparse_polynomial_multiply

module tb_sparse_polynomial_multiply;

   localparam int MaxTerms = 8;

   typedef struct packed {
      logic                     poly_select;
      logic signed [15:0]       term_coefficient;
      logic [14:0]              term_exponent;
      logic                     last_term;
   } term_type;

   typedef struct packed {
      logic signed [37:0]       product_coefficient;
      logic [15:0]              product_exponent;
      logic                     term_valid;
      logic                     capacity_overflow;
      logic                     last_result;
   } prod_type;

   typedef struct {
      term_type t;
      bit       typed;
      prod_type want;
   } row_type;

   logic clock = 0;
   logic reset = 1;

   spm_req_if req_bus ();
   spm_rsp_if rsp_bus ();

   sparse_polynomial_multiply #(.MAX_TERMS(MaxTerms)) uut (
      .clock(clock), .reset(reset), .req_channel(req_bus.sink), .rsp_channel(rsp_bus.source)
   );

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   logic signed [15:0] first_coef [MaxTerms];
   logic [14:0]        first_exp [MaxTerms];
   logic signed [15:0] second_coef [MaxTerms];
   logic [14:0]        second_exp [MaxTerms];
   int                 first_n, second_n;
   bit                 dropped;
   prod_type           expected_terms[$];
   int                 errors = 0;
   bit                 stim_done = 0;

   task automatic report(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
   endtask

   // fold one accepted term into the job and queue its products on close
   task automatic predict_term(input term_type t);
      logic signed [37:0] sum_c [$];
      logic [15:0]        sum_e [$];
      logic signed [37:0] c;
      logic [15:0]        e;
      bit                 hit;
      int                 n;
      prod_type           p;
      if (!t.poly_select) begin
         if (first_n < MaxTerms) begin
            first_coef[first_n] = t.term_coefficient;
            first_exp[first_n] = t.term_exponent;
            first_n++;
         end else dropped = 1;
         return;
      end
      if (second_n < MaxTerms) begin
         second_coef[second_n] = t.term_coefficient;
         second_exp[second_n] = t.term_exponent;
         second_n++;
      end else dropped = 1;
      if (!t.last_term) return;
      for (int i = 0; i < first_n; i++)
         for (int j = 0; j < second_n; j++) begin
            c = 38'(first_coef[i] * second_coef[j]);
            e = 16'(first_exp[i]) + 16'(second_exp[j]);
            hit = 0;
            foreach (sum_e[k]) if (sum_e[k] == e) begin
               sum_c[k] += c;
               hit = 1;
            end
            if (!hit) begin
               sum_c.push_back(c);
               sum_e.push_back(e);
            end
         end
      n = 0;
      while (sum_e.size() > 0) begin
         int b;
         b = 0;
         foreach (sum_e[k]) if (sum_e[k] > sum_e[b]) b = k;
         if (sum_c[b] != 0) begin
            p = '{sum_c[b], sum_e[b], 1'b1, dropped, 1'b0};
            expected_terms.push_back(p);
            n++;
         end
         sum_c.delete(b);
         sum_e.delete(b);
      end
      if (n == 0) expected_terms.push_back(prod_type'{38'sd0, 16'd0, 1'b0, dropped, 1'b1});
      else expected_terms[$].last_result = 1;
      first_n = 0;
      second_n = 0;
      dropped = 0;
   endtask

   row_type rows[$];

   function automatic term_type mk(bit s, int c, int e, bit l);
      return term_type'{s, 16'(c), 15'(e), l};
   endfunction

   task automatic add(input term_type t);
      row_type r;
      r.t = t; r.typed = 0; r.want = '0;
      rows.push_back(r);
   endtask

   task automatic add_typed(input term_type t, input prod_type w);
      row_type r;
      r.t = t; r.typed = 1; r.want = w;
      rows.push_back(r);
   endtask

   task automatic send(input term_type t);
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
      if (gap != 0) begin
         req_bus.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1;
      {req_bus.poly_select, req_bus.term_coefficient, req_bus.term_exponent,
       req_bus.last_term} <= t;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_term(t);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 0;
      @(posedge clock);
      while (expected_terms.size() != 0) @(posedge clock);
   endtask

   function automatic term_type rand_term(bit s, bit l, int span);
      term_type t;
      t.poly_select = s;
      t.last_term = l;
      case ($urandom_range(0, 5))
         0: t.term_coefficient = 16'sh8000;
         1: t.term_coefficient = 16'sh7fff;
         2: t.term_coefficient = 16'($urandom_range(0, 6)) - 16'sd3;
         default: t.term_coefficient = 16'($urandom);
      endcase
      if (span == 0) t.term_exponent = 15'($urandom);
      else t.term_exponent = 15'($urandom_range(0, span));
      return t;
   endfunction

   initial begin
      req_bus.valid = 0;
      req_bus.poly_select = 0;
      req_bus.term_coefficient = 0;
      req_bus.term_exponent = 0;
      req_bus.last_term = 0;
      first_n = 0; second_n = 0; dropped = 0;
      repeat (5) @(posedge clock);
      reset <= 0;

      // empty first list
      add_typed(mk(1, 5, 3, 1), prod_type'{38'sd0, 16'd0, 1'b0, 1'b0, 1'b1});
      // extremes: single term product
      add(mk(0, -32768, 32767, 1));
      add_typed(mk(1, -32768, 32767, 1),
                prod_type'{38'sd1073741824, 16'd65534, 1'b1, 1'b0, 1'b1});
      // (x+1)(x-1): middle terms cancel, leaves x^2-1
      add(mk(0, 1, 1, 0)); add(mk(0, 1, 0, 1));
      add(mk(1, 1, 1, 0)); add(mk(1, -1, 0, 1));
      // zero coefficients cancel everything
      add(mk(0, 0, 4, 1));
      add_typed(mk(1, 7, 2, 1), prod_type'{38'sd0, 16'd0, 1'b0, 1'b0, 1'b1});
      // first list closing then appended again, overflow on both lists
      for (int i = 0; i < 9; i++) add(mk(0, 32767, i, i == 3));
      for (int i = 0; i < 8; i++) add(mk(1, -32768, 100 * i, 0));
      add(mk(1, 1, 9, 1));
      foreach (rows[i]) begin
         send(rows[i].t);
         if (rows[i].typed) begin
            if (expected_terms.size() == 0 || expected_terms[$] != rows[i].want)
               report("predictor disagrees with table");
            wait_drained();
         end
      end
      wait_drained();

      for (int job = 0; job < 40; job++) begin
         int n1, n2, span;
         n1 = $urandom_range(0, 7) == 0 ? $urandom_range(0, 10) : $urandom_range(1, 5);
         n2 = $urandom_range(0, 7) == 0 ? $urandom_range(1, 10) : $urandom_range(1, 5);
         span = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 12);
         for (int i = 0; i < n1; i++) send(rand_term(0, $urandom_range(0, 3) == 0, span));
         for (int i = 0; i < n2; i++) begin
            if ($urandom_range(0, 9) == 0) send(rand_term(0, 1'($urandom), span));
            send(rand_term(1, i == n2 - 1, span));
         end
         if (job % 10 == 5) wait_drained();
      end
      req_bus.valid <= 0;
      stim_done = 1;
   end

   prod_type got;
   prod_type want;
   int       rsp_wait;

   initial begin
      rsp_bus.ready = 0;
      rsp_wait = $urandom_range(0, 14);
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.product_coefficient, rsp_bus.product_exponent,
                   rsp_bus.term_valid, rsp_bus.capacity_overflow, rsp_bus.last_result};
            if (expected_terms.size() == 0) report("response with nothing expected");
            else begin
               want = expected_terms.pop_front();
               if (got.product_coefficient !== want.product_coefficient)
                  report($sformatf("coefficient %0d want %0d", got.product_coefficient,
                                   want.product_coefficient));
               if (got.product_exponent !== want.product_exponent)
                  report($sformatf("exponent %0d want %0d", got.product_exponent,
                                   want.product_exponent));
               if (got.term_valid !== want.term_valid) report("term_valid");
               if (got.capacity_overflow !== want.capacity_overflow)
                  report("capacity_overflow");
               if (got.last_result !== want.last_result) report("last_result");
            end
            rsp_wait = $urandom_range(0, 14);
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_bus.ready <= (rsp_wait == 0);
      end
   end

   initial begin
      @(posedge stim_done);
      while (expected_terms.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0) $display("sparse_polynomial_multiply regression: pass");
      else $display("sparse_polynomial_multiply regression: fail");
      $finish;
   end

   initial begin
      #4000000;
      $display("sparse_polynomial_multiply regression: fail");
      $finish;
   end

endmodule
